FILE: sv/ddoi_pkg.sv
// Shared types, widths, register indexes and constant tables for the
// differential drive odometry integrator. No dependencies.
package ddoi_pkg;

   // Field widths of the channels.
   localparam int SPEED_W   = 16;
   localparam int TSTEP_W   = 16;
   localparam int POS_W     = 32;
   localparam int HEAD_W    = 20;
   localparam int QUAT_W    = 16;
   localparam int MEAN_W    = 17;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 4;

   // Internal datapath widths.
   localparam int XY_W   = 33;
   localparam int ANG_W  = 36;
   localparam int MA_W   = 36;
   localparam int MB_W   = 24;
   localparam int PROD_W = 60;
   localparam int DX_W   = 24;
   localparam int PX_W   = 32;
   localparam int QUO_W  = 33;
   localparam int REM_W  = 16;
   localparam int CNT_W  = 6;
   localparam int IDX_W  = 5;

   // Rotation count of the CORDIC, capped at the table depth.
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_ITERS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_WHEEL_BASE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_GAIN = 4'd1;

   localparam logic [CFG_W-1:0] WHEEL_BASE_RST = 16'd77;
   localparam logic [CFG_W-1:0] SPEED_GAIN_RST = 16'd6963;

   // Angle constants in Q30 radians.
   localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [XY_W-1:0]  CORDIC_START = 33'sd652032874;

   // Heading wrap limit in Q3.16.
   localparam logic signed [HEAD_W+1:0] HEADING_WRAP = 22'sd411775;

   // Sequencer states.
   typedef enum logic [4:0] {
      S_IDLE,
      S_MEAN,
      S_DG,
      S_DGT,
      S_DIV_INIT,
      S_DIV,
      S_STEP,
      S_ROT_LOAD,
      S_ROT_WRAP,
      S_ROT_FOLD,
      S_ROT,
      S_ROT_END,
      S_MDX,
      S_MDXR,
      S_MDYR,
      S_P1,
      S_P2,
      S_P3,
      S_P4,
      S_P5,
      S_P6,
      S_UPD,
      S_EMIT
   } state_type;

   // Which angle the shared CORDIC is working on.
   typedef enum logic [1:0] {
      PASS_STEP,
      PASS_HEAD,
      PASS_HALF
   } pass_type;

   // Arctangent of 2^-i in Q30 radians.
   function automatic logic signed [ANG_W-1:0] atan_q30(input logic [IDX_W-1:0] i);
      logic signed [ANG_W-1:0] v;
      begin
         unique case (i)
            5'd0:  v = 36'sh03243F6A8;
            5'd1:  v = 36'sh01DAC6705;
            5'd2:  v = 36'sh00FADBAFC;
            5'd3:  v = 36'sh007F56EA6;
            5'd4:  v = 36'sh003FEAB76;
            5'd5:  v = 36'sh001FFD55B;
            5'd6:  v = 36'sh000FFFAAA;
            5'd7:  v = 36'sh0007FFF55;
            5'd8:  v = 36'sh0003FFFEA;
            5'd9:  v = 36'sh0001FFFFD;
            5'd10: v = 36'sh0000FFFFF;
            5'd11: v = 36'sh00007FFFF;
            5'd12: v = 36'sh00003FFFF;
            5'd13: v = 36'sh00001FFFF;
            5'd14: v = 36'sh00000FFFF;
            5'd15: v = 36'sh000007FFF;
            5'd16: v = 36'sh000003FFF;
            5'd17: v = 36'sh000001FFF;
            5'd18: v = 36'sh000000FFF;
            5'd19: v = 36'sh0000007FF;
            5'd20: v = 36'sh0000003FF;
            5'd21: v = 36'sh0000001FF;
            5'd22: v = 36'sh0000000FF;
            5'd23: v = 36'sh00000007F;
            5'd24: v = 36'sh00000003F;
            5'd25: v = 36'sh00000001F;
            5'd26: v = 36'sh00000000F;
            5'd27: v = 36'sh000000008;
            5'd28: v = 36'sh000000004;
            5'd29: v = 36'sh000000002;
            5'd30: v = 36'sh000000001;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

FILE: sv/ddoi_if.sv
// Valid/ready channel interfaces for the odometry integrator: request,
// response and register write. Depends on ddoi_pkg for field widths.
interface ddoi_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ddoi_pkg::SPEED_W-1:0]   first_speed;
   logic signed [ddoi_pkg::SPEED_W-1:0]   second_speed;
   logic        [ddoi_pkg::TSTEP_W-1:0]   time_step;

   modport source (output valid, first_speed, second_speed, time_step, input ready);
   modport sink   (input valid, first_speed, second_speed, time_step, output ready);
endinterface

interface ddoi_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ddoi_pkg::POS_W-1:0]    x_position;
   logic signed [ddoi_pkg::POS_W-1:0]    y_position;
   logic signed [ddoi_pkg::HEAD_W-1:0]   heading_angle;
   logic signed [ddoi_pkg::QUAT_W-1:0]   orient_z;
   logic signed [ddoi_pkg::QUAT_W-1:0]   orient_w;
   logic signed [ddoi_pkg::MEAN_W-1:0]   mean_speed;
   logic signed [ddoi_pkg::HEAD_W-1:0]   heading_step;
   logic                                 wheels_stopped;

   modport source (output valid, x_position, y_position, heading_angle, orient_z,
                   orient_w, mean_speed, heading_step, wheels_stopped, input ready);
   modport sink   (input valid, x_position, y_position, heading_angle, orient_z,
                   orient_w, mean_speed, heading_step, wheels_stopped, output ready);
endinterface

interface ddoi_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ddoi_pkg::CSR_IDX_W-1:0]      index;
   logic [ddoi_pkg::CFG_W-1:0]          data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/diff_drive_odometry_integrator_unit.sv
// Top level of the differential drive odometry integrator: sequencer,
// shared multiplier, divider and CORDIC. Depends on ddoi_pkg and ddoi_if.
//
// Usage: a request beat on req_bus carries two signed Q4.12 wheel speeds
// (first is the right wheel, second the left) and an unsigned Q0.16 time
// step. Each request produces exactly one response beat on rsp_bus with the
// updated pose (x, y, heading), the yaw quaternion z and w, the mean speed,
// the heading step and a stopped flag. Registers wheel_base (index 0) and
// speed_gain (index 1) are written on csr_bus, which is always ready.
// One request is worked through one restoring divider, three passes through a
// single CORDIC rotator and one multiplier shared by all products; a new
// request is taken only after the response of the last one is loaded.
// req_bus.ready is high only while the sequencer is idle.
// Reset (synchronous, active high) clears the pose to zero and restores the
// register defaults. The response sits in an output register; when the
// receiver stalls, the next result waits in its final cycle until that
// register is free, and the following request waits with it.
module diff_drive_odometry_integrator_unit (
   input logic        clock,
   input logic        reset,
   ddoi_req_if.sink   req_bus,
   ddoi_rsp_if.source rsp_bus,
   ddoi_csr_if.sink   csr_bus
);

   ddoi_pkg::state_type state_ff, state_in;
   ddoi_pkg::pass_type  pass_ff;

   // Configuration registers.
   logic [ddoi_pkg::CFG_W-1:0] wheel_base_ff;
   logic [ddoi_pkg::CFG_W-1:0] speed_gain_ff;

   // Captured request.
   logic signed [ddoi_pkg::SPEED_W-1:0] f_ff, s_ff;
   logic        [ddoi_pkg::TSTEP_W-1:0] t_ff;
   logic                                stopped_ff;

   // Kept pose.
   logic signed [ddoi_pkg::POS_W-1:0]  x_accum_ff, y_accum_ff;
   logic signed [ddoi_pkg::HEAD_W-1:0] heading_ff;

   // Working registers.
   logic signed [ddoi_pkg::PROD_W-1:0] prod_ff, acc_ff;
   logic signed [ddoi_pkg::MEAN_W-1:0] mean_ff;
   logic signed [ddoi_pkg::HEAD_W-1:0] step_ff;
   logic                               num_neg_ff;
   logic        [ddoi_pkg::QUO_W-1:0]  quo_ff;
   logic        [ddoi_pkg::REM_W-1:0]  rem_ff;
   logic        [ddoi_pkg::CNT_W-1:0]  cnt_ff;
   logic signed [ddoi_pkg::ANG_W-1:0]  ang_ff;
   logic signed [ddoi_pkg::XY_W-1:0]   x_ff, y_ff, c_ff, s_trig_ff;
   logic                               neg_ff;
   logic signed [ddoi_pkg::DX_W-1:0]   dx_ff, dy_ff;
   logic signed [ddoi_pkg::PX_W-1:0]   px_ff, py_ff;

   // Response register.
   logic                                rsp_valid_ff;
   logic signed [ddoi_pkg::POS_W-1:0]   rsp_x_ff, rsp_y_ff;
   logic signed [ddoi_pkg::HEAD_W-1:0]  rsp_head_ff, rsp_step_ff;
   logic signed [ddoi_pkg::QUAT_W-1:0]  rsp_z_ff, rsp_w_ff;
   logic signed [ddoi_pkg::MEAN_W-1:0]  rsp_mean_ff;
   logic                                rsp_stop_ff;

   // Combinational helpers.
   logic                                req_take, rsp_free;
   logic signed [ddoi_pkg::MA_W-1:0]    mul_a;
   logic signed [ddoi_pkg::MB_W-1:0]    mul_b;
   logic signed [ddoi_pkg::PROD_W-1:0]  mul_prod;
   logic signed [ddoi_pkg::MEAN_W-1:0]  sum17, diff17;
   logic signed [ddoi_pkg::MB_W-1:0]    gain_b;
   logic        [ddoi_pkg::CFG_W-1:0]   w_eff;
   logic        [ddoi_pkg::REM_W:0]     div_trial;
   logic                                div_ge;
   logic signed [ddoi_pkg::ANG_W-1:0]   ang_src;
   logic signed [ddoi_pkg::XY_W-1:0]    x_sh, y_sh;
   logic signed [ddoi_pkg::ANG_W-1:0]   atan_v;
   logic signed [ddoi_pkg::PROD_W-1:0]  mean_sh, acc_rnd;
   logic signed [ddoi_pkg::PROD_W-1:0]  prod_rnd26;
   logic signed [ddoi_pkg::PROD_W-1:0]  num_mag;
   logic signed [ddoi_pkg::POS_W+1:0]   x_sum, y_sum;
   logic signed [ddoi_pkg::HEAD_W+1:0]  h_new;
   logic signed [ddoi_pkg::XY_W-1:0]    z_rnd, w_rnd;
   logic signed [ddoi_pkg::QUAT_W-1:0]  z_sat, w_sat;

   localparam logic [ddoi_pkg::CNT_W-1:0] DIV_LAST =
      ddoi_pkg::CNT_W'(ddoi_pkg::QUO_W - 1);
   localparam logic [ddoi_pkg::CNT_W-1:0] ROT_LAST =
      ddoi_pkg::CNT_W'(ddoi_pkg::CORDIC_ITERS - 1);

   assign req_take = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ddoi_pkg::S_IDLE:     if (req_bus.valid) state_in = ddoi_pkg::S_MEAN;
         ddoi_pkg::S_MEAN:     state_in = ddoi_pkg::S_DG;
         ddoi_pkg::S_DG:       state_in = ddoi_pkg::S_DGT;
         ddoi_pkg::S_DGT:      state_in = ddoi_pkg::S_DIV_INIT;
         ddoi_pkg::S_DIV_INIT: state_in = ddoi_pkg::S_DIV;
         ddoi_pkg::S_DIV:      if (cnt_ff == DIV_LAST) state_in = ddoi_pkg::S_STEP;
         ddoi_pkg::S_STEP:     state_in = ddoi_pkg::S_ROT_LOAD;
         ddoi_pkg::S_ROT_LOAD: state_in = ddoi_pkg::S_ROT_WRAP;
         ddoi_pkg::S_ROT_WRAP: state_in = ddoi_pkg::S_ROT_FOLD;
         ddoi_pkg::S_ROT_FOLD: state_in = ddoi_pkg::S_ROT;
         ddoi_pkg::S_ROT:      if (cnt_ff == ROT_LAST) state_in = ddoi_pkg::S_ROT_END;
         ddoi_pkg::S_ROT_END: begin
            unique case (pass_ff)
               ddoi_pkg::PASS_STEP: state_in = ddoi_pkg::S_MDX;
               ddoi_pkg::PASS_HEAD: state_in = ddoi_pkg::S_P1;
               default:             state_in = ddoi_pkg::S_EMIT;
            endcase
         end
         ddoi_pkg::S_MDX:      state_in = ddoi_pkg::S_MDXR;
         ddoi_pkg::S_MDXR:     state_in = ddoi_pkg::S_MDYR;
         ddoi_pkg::S_MDYR:     state_in = ddoi_pkg::S_ROT_LOAD;
         ddoi_pkg::S_P1:       state_in = ddoi_pkg::S_P2;
         ddoi_pkg::S_P2:       state_in = ddoi_pkg::S_P3;
         ddoi_pkg::S_P3:       state_in = ddoi_pkg::S_P4;
         ddoi_pkg::S_P4:       state_in = ddoi_pkg::S_P5;
         ddoi_pkg::S_P5:       state_in = ddoi_pkg::S_P6;
         ddoi_pkg::S_P6:       state_in = ddoi_pkg::S_UPD;
         ddoi_pkg::S_UPD:      state_in = ddoi_pkg::S_ROT_LOAD;
         ddoi_pkg::S_EMIT:     if (rsp_free) state_in = ddoi_pkg::S_IDLE;
         default:              state_in = ddoi_pkg::S_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and shared multiplier operands.
   always_comb begin
      req_bus.ready = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      unique case (state_ff)
         ddoi_pkg::S_IDLE: req_bus.ready = 1'b1;
         ddoi_pkg::S_MEAN: begin
            mul_a = ddoi_pkg::MA_W'(sum17);
            mul_b = gain_b;
         end
         ddoi_pkg::S_DG: begin
            mul_a = ddoi_pkg::MA_W'(diff17);
            mul_b = gain_b;
         end
         ddoi_pkg::S_DGT: begin
            mul_a = ddoi_pkg::MA_W'(prod_ff);
            mul_b = ddoi_pkg::MB_W'($signed({1'b0, t_ff}));
         end
         ddoi_pkg::S_MDX: begin
            mul_a = ddoi_pkg::MA_W'(c_ff);
            mul_b = ddoi_pkg::MB_W'(mean_ff);
         end
         ddoi_pkg::S_MDXR: begin
            mul_a = ddoi_pkg::MA_W'(s_trig_ff);
            mul_b = ddoi_pkg::MB_W'(mean_ff);
         end
         ddoi_pkg::S_P1: begin
            mul_a = ddoi_pkg::MA_W'(c_ff);
            mul_b = dx_ff;
         end
         ddoi_pkg::S_P2: begin
            mul_a = ddoi_pkg::MA_W'(s_trig_ff);
            mul_b = dy_ff;
         end
         ddoi_pkg::S_P3: begin
            mul_a = ddoi_pkg::MA_W'(s_trig_ff);
            mul_b = dx_ff;
         end
         ddoi_pkg::S_P4: begin
            mul_a = ddoi_pkg::MA_W'(c_ff);
            mul_b = dy_ff;
         end
         default: ;
      endcase
   end

   // Shared multiplier; its product is always registered in prod_ff.
   assign mul_prod = mul_a * mul_b;

   // Speed sum and difference, gain as a signed operand, safe wheel base.
   assign sum17  = ddoi_pkg::MEAN_W'(f_ff) + ddoi_pkg::MEAN_W'(s_ff);
   assign diff17 = ddoi_pkg::MEAN_W'(f_ff) - ddoi_pkg::MEAN_W'(s_ff);
   assign gain_b = ddoi_pkg::MB_W'($signed({1'b0, speed_gain_ff}));
   assign w_eff  = (wheel_base_ff == '0) ? ddoi_pkg::CFG_W'(1) : wheel_base_ff;

   // One restoring division step per cycle.
   assign div_trial = {rem_ff, quo_ff[ddoi_pkg::QUO_W-1]};
   assign div_ge    = div_trial >= {1'b0, w_eff};

   // Angle source of the current CORDIC pass, in Q30, sign extended.
   always_comb begin
      unique case (pass_ff)
         ddoi_pkg::PASS_STEP: ang_src = ddoi_pkg::ANG_W'($signed({step_ff, 14'b0}));
         ddoi_pkg::PASS_HEAD: ang_src = ddoi_pkg::ANG_W'($signed({heading_ff, 14'b0}));
         default:             ang_src = ddoi_pkg::ANG_W'($signed({heading_ff, 13'b0}));
      endcase
   end

   // CORDIC shifted terms and table value.
   assign x_sh   = x_ff >>> cnt_ff[ddoi_pkg::IDX_W-1:0];
   assign y_sh   = y_ff >>> cnt_ff[ddoi_pkg::IDX_W-1:0];
   assign atan_v = ddoi_pkg::atan_q30(cnt_ff[ddoi_pkg::IDX_W-1:0]);

   // Rounding and scaling helpers.
   assign mean_sh    = prod_ff >>> 13;
   assign prod_rnd26 = (prod_ff + (ddoi_pkg::PROD_W'(1) <<< 25)) >>> 26;
   assign acc_rnd    = (acc_ff + (ddoi_pkg::PROD_W'(1) <<< 29)) >>> 30;
   assign num_mag    = prod_ff[ddoi_pkg::PROD_W-1] ? -prod_ff : prod_ff;

   // Position sums with room for the saturation test.
   assign x_sum = ddoi_pkg::POS_W'(x_accum_ff) + (ddoi_pkg::POS_W + 2)'(px_ff);
   assign y_sum = ddoi_pkg::POS_W'(y_accum_ff) + (ddoi_pkg::POS_W + 2)'(py_ff);

   // Heading advance with the wrap applied up to twice.
   always_comb begin
      h_new = (ddoi_pkg::HEAD_W + 2)'(heading_ff) + (ddoi_pkg::HEAD_W + 2)'(step_ff);
      if (h_new >= ddoi_pkg::HEADING_WRAP)  h_new = h_new - ddoi_pkg::HEADING_WRAP;
      if (h_new <= -ddoi_pkg::HEADING_WRAP) h_new = h_new + ddoi_pkg::HEADING_WRAP;
      if (h_new >= ddoi_pkg::HEADING_WRAP)  h_new = h_new - ddoi_pkg::HEADING_WRAP;
      if (h_new <= -ddoi_pkg::HEADING_WRAP) h_new = h_new + ddoi_pkg::HEADING_WRAP;
   end

   // Quaternion terms from the half-heading sine and cosine, Q30 to Q14.
   assign z_rnd = (s_trig_ff + (ddoi_pkg::XY_W'(1) <<< 15)) >>> 16;
   assign w_rnd = (c_ff + (ddoi_pkg::XY_W'(1) <<< 15)) >>> 16;
   always_comb begin
      if (z_rnd > 33'sd16384)       z_sat = 16'sd16384;
      else if (z_rnd < -33'sd16384) z_sat = -16'sd16384;
      else                          z_sat = ddoi_pkg::QUAT_W'(z_rnd);
      if (w_rnd > 33'sd16384)       w_sat = 16'sd16384;
      else if (w_rnd < -33'sd16384) w_sat = -16'sd16384;
      else                          w_sat = ddoi_pkg::QUAT_W'(w_rnd);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ddoi_pkg::S_IDLE;
         pass_ff       <= ddoi_pkg::PASS_STEP;
         wheel_base_ff <= ddoi_pkg::WHEEL_BASE_RST;
         speed_gain_ff <= ddoi_pkg::SPEED_GAIN_RST;
         x_accum_ff    <= '0;
         y_accum_ff    <= '0;
         heading_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Register writes.
         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               ddoi_pkg::REG_WHEEL_BASE: wheel_base_ff <= csr_bus.data;
               ddoi_pkg::REG_SPEED_GAIN: speed_gain_ff <= csr_bus.data;
               default: ;
            endcase
         end

         // CORDIC pass selection.
         if (state_ff == ddoi_pkg::S_STEP) pass_ff <= ddoi_pkg::PASS_STEP;
         if (state_ff == ddoi_pkg::S_MDYR) pass_ff <= ddoi_pkg::PASS_HEAD;
         if (state_ff == ddoi_pkg::S_UPD)  pass_ff <= ddoi_pkg::PASS_HALF;

         // Pose update with saturation.
         if (state_ff == ddoi_pkg::S_UPD) begin
            if (x_sum > (ddoi_pkg::POS_W + 2)'(32'sh7FFFFFFF))
               x_accum_ff <= 32'sh7FFFFFFF;
            else if (x_sum < -(ddoi_pkg::POS_W + 2)'(34'sh080000000))
               x_accum_ff <= 32'sh80000000;
            else
               x_accum_ff <= ddoi_pkg::POS_W'(x_sum);
            if (y_sum > (ddoi_pkg::POS_W + 2)'(32'sh7FFFFFFF))
               y_accum_ff <= 32'sh7FFFFFFF;
            else if (y_sum < -(ddoi_pkg::POS_W + 2)'(34'sh080000000))
               y_accum_ff <= 32'sh80000000;
            else
               y_accum_ff <= ddoi_pkg::POS_W'(y_sum);
            heading_ff <= ddoi_pkg::HEAD_W'(h_new);
         end

         // Response register.
         if (state_ff == ddoi_pkg::S_EMIT && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready)                       rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      // Capture the request beat.
      if (req_take) begin
         f_ff       <= req_bus.first_speed;
         s_ff       <= req_bus.second_speed;
         t_ff       <= req_bus.time_step;
         stopped_ff <= (req_bus.first_speed == '0) && (req_bus.second_speed == '0);
      end

      case (state_ff)
         ddoi_pkg::S_MEAN, ddoi_pkg::S_DGT: prod_ff <= mul_prod;
         ddoi_pkg::S_DG: begin
            // Mean speed, floored and saturated to 17 bits.
            if (mean_sh > ddoi_pkg::PROD_W'(65535))       mean_ff <= 17'sd65535;
            else if (mean_sh < -ddoi_pkg::PROD_W'(65536)) mean_ff <= -17'sd65536;
            else                                          mean_ff <= ddoi_pkg::MEAN_W'(mean_sh);
            prod_ff <= mul_prod;
         end
         ddoi_pkg::S_DIV_INIT: begin
            num_neg_ff <= prod_ff[ddoi_pkg::PROD_W-1];
            quo_ff     <= num_mag[16 +: ddoi_pkg::QUO_W];
            rem_ff     <= '0;
            cnt_ff     <= '0;
         end
         ddoi_pkg::S_DIV: begin
            rem_ff <= div_ge ? ddoi_pkg::REM_W'(div_trial - {1'b0, w_eff})
                             : ddoi_pkg::REM_W'(div_trial);
            quo_ff <= {quo_ff[ddoi_pkg::QUO_W-2:0], div_ge};
            cnt_ff <= cnt_ff + 1'b1;
         end
         ddoi_pkg::S_STEP: begin
            // Heading step, signed and saturated.
            if (num_neg_ff) begin
               if (quo_ff > 33'd524288) step_ff <= -20'sd524288;
               else                     step_ff <= -$signed(ddoi_pkg::HEAD_W'(quo_ff));
            end else begin
               if (quo_ff > 33'd524287) step_ff <= 20'sd524287;
               else                     step_ff <= $signed(ddoi_pkg::HEAD_W'(quo_ff));
            end
         end
         ddoi_pkg::S_ROT_LOAD: begin
            ang_ff <= (ang_src > ddoi_pkg::PI_Q30) ? ang_src - ddoi_pkg::TWO_PI_Q30 : ang_src;
         end
         ddoi_pkg::S_ROT_WRAP: begin
            if (ang_ff < -ddoi_pkg::PI_Q30) ang_ff <= ang_ff + ddoi_pkg::TWO_PI_Q30;
         end
         ddoi_pkg::S_ROT_FOLD: begin
            // Fold into the right half plane and start the rotator.
            if (ang_ff > ddoi_pkg::HALF_PI_Q30) begin
               ang_ff <= ang_ff - ddoi_pkg::PI_Q30;
               neg_ff <= 1'b1;
            end else if (ang_ff < -ddoi_pkg::HALF_PI_Q30) begin
               ang_ff <= ang_ff + ddoi_pkg::PI_Q30;
               neg_ff <= 1'b1;
            end else begin
               neg_ff <= 1'b0;
            end
            x_ff   <= ddoi_pkg::CORDIC_START;
            y_ff   <= '0;
            cnt_ff <= '0;
         end
         ddoi_pkg::S_ROT: begin
            // One CORDIC rotation per cycle.
            if (!ang_ff[ddoi_pkg::ANG_W-1]) begin
               x_ff   <= x_ff - y_sh;
               y_ff   <= y_ff + x_sh;
               ang_ff <= ang_ff - atan_v;
            end else begin
               x_ff   <= x_ff + y_sh;
               y_ff   <= y_ff - x_sh;
               ang_ff <= ang_ff + atan_v;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
         ddoi_pkg::S_ROT_END: begin
            c_ff      <= neg_ff ? -x_ff : x_ff;
            s_trig_ff <= neg_ff ? -y_ff : y_ff;
         end
         ddoi_pkg::S_MDX: prod_ff <= mul_prod;
         ddoi_pkg::S_MDXR: begin
            dx_ff   <= ddoi_pkg::DX_W'(prod_rnd26);
            prod_ff <= mul_prod;
         end
         ddoi_pkg::S_MDYR: dy_ff <= ddoi_pkg::DX_W'(prod_rnd26);
         ddoi_pkg::S_P1: prod_ff <= mul_prod;
         ddoi_pkg::S_P2: begin
            acc_ff  <= prod_ff;
            prod_ff <= mul_prod;
         end
         ddoi_pkg::S_P3: begin
            acc_ff  <= acc_ff - prod_ff;
            prod_ff <= mul_prod;
         end
         ddoi_pkg::S_P4: begin
            px_ff   <= ddoi_pkg::PX_W'(acc_rnd);
            acc_ff  <= prod_ff;
            prod_ff <= mul_prod;
         end
         ddoi_pkg::S_P5: acc_ff <= acc_ff + prod_ff;
         ddoi_pkg::S_P6: py_ff <= ddoi_pkg::PX_W'(acc_rnd);
         ddoi_pkg::S_EMIT: begin
            if (rsp_free) begin
               rsp_x_ff    <= x_accum_ff;
               rsp_y_ff    <= y_accum_ff;
               rsp_head_ff <= heading_ff;
               rsp_z_ff    <= z_sat;
               rsp_w_ff    <= w_sat;
               rsp_mean_ff <= mean_ff;
               rsp_step_ff <= step_ff;
               rsp_stop_ff <= stopped_ff;
            end
         end
         default: ;
      endcase
   end

   // Response port.
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.x_position     = rsp_x_ff;
   assign rsp_bus.y_position     = rsp_y_ff;
   assign rsp_bus.heading_angle  = rsp_head_ff;
   assign rsp_bus.orient_z       = rsp_z_ff;
   assign rsp_bus.orient_w       = rsp_w_ff;
   assign rsp_bus.mean_speed     = rsp_mean_ff;
   assign rsp_bus.heading_step   = rsp_step_ff;
   assign rsp_bus.wheels_stopped = rsp_stop_ff;

   // Register port never stalls.
   assign csr_bus.ready = 1'b1;

   // The kept heading never leaves the wrap range.
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      (heading_ff < 20'sd411775) && (heading_ff > -20'sd411775))
      else $error("heading outside wrap range");

   // An accepted request always starts the sequence.
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ddoi_pkg::S_MEAN)
      else $error("request accepted without starting");

   // The rotator never runs past its last table entry.
   a_rot_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ddoi_pkg::S_ROT |-> cnt_ff <= ROT_LAST)
      else $error("CORDIC counter overrun");

   // Leaving the emit state always presents a result.
   a_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ddoi_pkg::S_EMIT && rsp_free) |=> rsp_valid_ff)
      else $error("result lost at emit");

endmodule

FILE: tb/tb.sv
// Self-checking bench for diff_drive_odometry_integrator_unit: drives wheel speed
// beats, predicts each pose beat with a fixed point model of its own and compares.
// Depends on ddoi_pkg, the ddoi channel interfaces and the unit itself.
module tb;

   // Arctangent of 2^-i in Q30 radians for the CORDIC predictor.
   localparam longint ARCTAN_Q30 [32] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
      64'h00000001, 64'h00000000};
   localparam longint WRAP_LIMIT = 411775;

   typedef struct {
      logic signed [ddoi_pkg::POS_W-1:0]  x_pos;
      logic signed [ddoi_pkg::POS_W-1:0]  y_pos;
      logic signed [ddoi_pkg::HEAD_W-1:0] heading;
      logic signed [ddoi_pkg::QUAT_W-1:0] quat_z;
      logic signed [ddoi_pkg::QUAT_W-1:0] quat_w;
      logic signed [ddoi_pkg::MEAN_W-1:0] mean;
      logic signed [ddoi_pkg::HEAD_W-1:0] step;
      logic                               stopped;
   } pose_beat_type;

   // Pose predictor and store of pending pose beats.
   class odometry_scoreboard_type;
      longint        base_reg, gain_reg, x_acc, y_acc, head_acc;
      pose_beat_type pending_poses[$];
      int            mismatches;

      function new();
         base_reg   = ddoi_pkg::WHEEL_BASE_RST;
         gain_reg   = ddoi_pkg::SPEED_GAIN_RST;
         x_acc      = 0;
         y_acc      = 0;
         head_acc   = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [ddoi_pkg::CSR_IDX_W-1:0] idx,
                              logic [ddoi_pkg::CFG_W-1:0] val);
         if (idx == ddoi_pkg::REG_WHEEL_BASE) base_reg = val;
         else if (idx == ddoi_pkg::REG_SPEED_GAIN) gain_reg = val;
      endfunction

      static function longint rnd_shift(longint v, int sh);
         return (v + (longint'(1) << (sh - 1))) >>> sh;
      endfunction

      static function longint sat(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      // Cosine and sine in Q30 of a Q30 angle below three pi in magnitude.
      static function void cordic(longint ang, output longint c, output longint s);
         longint cx, cy, nx;
         bit     flip;
         int     n;
         cx   = longint'(ddoi_pkg::CORDIC_START);
         cy   = 0;
         flip = 0;
         n    = ddoi_pkg::CORDIC_STEPS > 32 ? 32 : ddoi_pkg::CORDIC_STEPS;
         if (ang > longint'(ddoi_pkg::PI_Q30)) ang -= longint'(ddoi_pkg::TWO_PI_Q30);
         if (ang < -longint'(ddoi_pkg::PI_Q30)) ang += longint'(ddoi_pkg::TWO_PI_Q30);
         if (ang > longint'(ddoi_pkg::HALF_PI_Q30)) begin
            ang -= longint'(ddoi_pkg::PI_Q30);
            flip = 1;
         end else if (ang < -longint'(ddoi_pkg::HALF_PI_Q30)) begin
            ang += longint'(ddoi_pkg::PI_Q30);
            flip = 1;
         end
         for (int i = 0; i < n; i++) begin
            if (ang >= 0) begin
               nx  = cx - (cy >>> i);
               cy  = cy + (cx >>> i);
               ang -= ARCTAN_Q30[i];
            end else begin
               nx  = cx + (cy >>> i);
               cy  = cy - (cx >>> i);
               ang += ARCTAN_Q30[i];
            end
            cx = nx;
         end
         c = flip ? -cx : cx;
         s = flip ? -cy : cy;
      endfunction

      // Advance the pose by one accepted speed beat and queue the expected result.
      function void note_request(logic signed [ddoi_pkg::SPEED_W-1:0] right,
                                 logic signed [ddoi_pkg::SPEED_W-1:0] left,
                                 logic [ddoi_pkg::TSTEP_W-1:0] dt);
         longint        f, s, g, w, mn, num, mag, q, stp, cd, sd, ch, sh, dx, dy, h, cz, sz;
         pose_beat_type e;
         f   = right;
         s   = left;
         g   = gain_reg;
         w   = base_reg == 0 ? 1 : base_reg;
         mn  = sat((f * g + s * g) >>> 13, -65536, 65535);
         num = (f - s) * g * longint'(dt);
         mag = num < 0 ? -num : num;
         q   = mag / (w << 16);
         if (num < 0) stp = q > 524288 ? -524288 : -q;
         else stp = q > 524287 ? 524287 : q;
         cordic(stp * 16384, cd, sd);
         dx = rnd_shift(cd * mn, 26);
         dy = rnd_shift(sd * mn, 26);
         cordic(head_acc * 16384, ch, sh);
         x_acc = sat(x_acc + rnd_shift(ch * dx - sh * dy, 30), -(longint'(1) << 31),
                     (longint'(1) << 31) - 1);
         y_acc = sat(y_acc + rnd_shift(sh * dx + ch * dy, 30), -(longint'(1) << 31),
                     (longint'(1) << 31) - 1);
         // The wrap is applied a second time only after a step beyond one turn.
         h = head_acc + stp;
         if (h >= WRAP_LIMIT) h -= WRAP_LIMIT;
         if (h <= -WRAP_LIMIT) h += WRAP_LIMIT;
         if (h >= WRAP_LIMIT) h -= WRAP_LIMIT;
         if (h <= -WRAP_LIMIT) h += WRAP_LIMIT;
         head_acc = h;
         cordic(h * 8192, cz, sz);
         e.x_pos   = ddoi_pkg::POS_W'(x_acc);
         e.y_pos   = ddoi_pkg::POS_W'(y_acc);
         e.heading = ddoi_pkg::HEAD_W'(h);
         e.quat_z  = ddoi_pkg::QUAT_W'(sat(rnd_shift(sz, 16), -16384, 16384));
         e.quat_w  = ddoi_pkg::QUAT_W'(sat(rnd_shift(cz, 16), -16384, 16384));
         e.mean    = ddoi_pkg::MEAN_W'(mn);
         e.step    = ddoi_pkg::HEAD_W'(stp);
         e.stopped = (f == 0 && s == 0);
         pending_poses.push_back(e);
      endfunction

      function void compare_field(string name, longint exp_v, longint act_v);
         if (exp_v != act_v) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch %s: expected %0d, got %0d", name, exp_v, act_v);
         end
      endfunction

      // Compare one accepted pose beat with the oldest expectation.
      function void check_response(pose_beat_type a);
         pose_beat_type e;
         if (pending_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: pose beat with nothing expected");
            return;
         end
         e = pending_poses.pop_front();
         compare_field("x_position", e.x_pos, a.x_pos);
         compare_field("y_position", e.y_pos, a.y_pos);
         compare_field("heading_angle", e.heading, a.heading);
         compare_field("orient_z", e.quat_z, a.quat_z);
         compare_field("orient_w", e.quat_w, a.quat_w);
         compare_field("mean_speed", e.mean, a.mean);
         compare_field("heading_step", e.step, a.step);
         compare_field("wheels_stopped", e.stopped, a.stopped);
      endfunction
   endclass

   logic clock;
   logic reset;
   ddoi_req_if req_bus();
   ddoi_rsp_if rsp_bus();
   ddoi_csr_if csr_bus();

   diff_drive_odometry_integrator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_bus(csr_bus.sink)
   );

   odometry_scoreboard_type pose_sb = new();
   int send_idle_pct = 22;
   int recv_idle_pct = 80;
   bit hold_request  = 0;
   bit hold_done     = 0;
   int hold_count    = 0;

   // Clock with a 12 unit period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: random stalls plus one long hold-off that lets the unit back up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready = 1'b0;
      end else if (hold_request && !hold_done) begin
         rsp_bus.ready = 1'b0;
         hold_count++;
         if (hold_count >= 600) hold_done = 1;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      pose_beat_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.x_pos   = rsp_bus.x_position;
         got.y_pos   = rsp_bus.y_position;
         got.heading = rsp_bus.heading_angle;
         got.quat_z  = rsp_bus.orient_z;
         got.quat_w  = rsp_bus.orient_w;
         got.mean    = rsp_bus.mean_speed;
         got.step    = rsp_bus.heading_step;
         got.stopped = rsp_bus.wheels_stopped;
         pose_sb.check_response(got);
      end
   end

   // Offer one speed beat, idling at random first; valid stays high afterward.
   task automatic send_speeds(logic signed [ddoi_pkg::SPEED_W-1:0] right,
                              logic signed [ddoi_pkg::SPEED_W-1:0] left,
                              logic [ddoi_pkg::TSTEP_W-1:0] dt);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.first_speed  = right;
      req_bus.second_speed = left;
      req_bus.time_step    = dt;
      do @(posedge clock); while (!req_bus.ready);
      pose_sb.note_request(right, left, dt);
   endtask

   // Write one register once the unit has drained.
   task automatic write_csr(logic [ddoi_pkg::CSR_IDX_W-1:0] idx,
                            logic [ddoi_pkg::CFG_W-1:0] val);
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pose_sb.pending_poses.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = val;
      do @(posedge clock); while (!csr_bus.ready);
      pose_sb.write_reg(idx, val);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Random speed beat: mostly full range, some slow or straight-line motion.
   task automatic send_random();
      int kind;
      logic signed [ddoi_pkg::SPEED_W-1:0] r, l;
      kind = $urandom_range(99);
      r    = ddoi_pkg::SPEED_W'($urandom);
      l    = ddoi_pkg::SPEED_W'($urandom);
      if (kind < 15) begin
         r = ddoi_pkg::SPEED_W'($signed($urandom_range(64)) - 32);
         l = ddoi_pkg::SPEED_W'($signed($urandom_range(64)) - 32);
      end else if (kind < 25) begin
         l = r;
      end else if (kind < 28) begin
         r = '0;
         l = '0;
      end
      send_speeds(r, l, ddoi_pkg::TSTEP_W'($urandom));
   endtask

   initial begin
      reset                = 1'b1;
      clock                = 1'b0;
      req_bus.valid        = 1'b0;
      req_bus.first_speed  = '0;
      req_bus.second_speed = '0;
      req_bus.time_step    = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = '0;
      csr_bus.data         = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed beats at reset settings: stopped wheels, extremes, heading wrap.
      send_speeds(16'sh0000, 16'sh0000, 16'hFFFF);
      send_speeds(16'sh7FFF, -16'sh8000, 16'hFFFF);
      send_speeds(-16'sh8000, 16'sh7FFF, 16'hFFFF);
      send_speeds(16'sh7FFF, 16'sh7FFF, 16'h0000);
      send_speeds(-16'sh8000, -16'sh8000, 16'h0001);
      send_speeds(16'sh1000, -16'sh1000, 16'h0000);
      for (int i = 0; i < 6; i++) send_speeds(16'sh4000, -16'sh4000, 16'h8000);
      for (int i = 0; i < 6; i++) send_speeds(-16'sh3000, 16'sh3000, 16'hC000);
      send_speeds(16'sh0001, 16'sh0000, 16'h0001);

      // Zero wheel base and full gain; an unused register index is ignored.
      write_csr(ddoi_pkg::REG_WHEEL_BASE, 16'd0);
      write_csr(ddoi_pkg::REG_SPEED_GAIN, 16'hFFFF);
      write_csr(ddoi_pkg::CSR_IDX_W'($urandom_range(2, 15)), 16'h1234);
      send_speeds(16'sh7FFF, -16'sh8000, 16'hFFFF);
      send_speeds(-16'sh8000, 16'sh7FFF, 16'hFFFF);
      send_speeds(16'sh0100, 16'sh0000, 16'h0400);

      // Straight full speed run that builds up a large position.
      write_csr(ddoi_pkg::REG_WHEEL_BASE, 16'd1);
      for (int i = 0; i < 300; i++)
         send_speeds(16'sh7FFF, 16'sh7FFF, ddoi_pkg::TSTEP_W'($urandom));

      // Random traffic in three idling modes with a setting change between.
      write_csr(ddoi_pkg::REG_WHEEL_BASE, 16'hFFFF);
      write_csr(ddoi_pkg::REG_SPEED_GAIN, 16'd0);
      send_idle_pct = 22;
      recv_idle_pct = 80;
      for (int i = 0; i < 270; i++) begin
         if (i == 60) hold_request = 1;
         if (i == 120) write_csr(ddoi_pkg::REG_SPEED_GAIN, 16'd6963);
         send_random();
      end
      write_csr(ddoi_pkg::REG_WHEEL_BASE, 16'd1);
      write_csr(ddoi_pkg::REG_SPEED_GAIN, 16'd4096);
      send_idle_pct = 80;
      recv_idle_pct = 22;
      for (int i = 0; i < 270; i++) send_random();
      write_csr(ddoi_pkg::REG_WHEEL_BASE, ddoi_pkg::CFG_W'($urandom));
      write_csr(ddoi_pkg::REG_SPEED_GAIN, ddoi_pkg::CFG_W'($urandom));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 260; i++) begin
         if (i == 180) begin
            write_csr(ddoi_pkg::REG_WHEEL_BASE, ddoi_pkg::CFG_W'($urandom_range(1, 300)));
            write_csr(ddoi_pkg::REG_SPEED_GAIN, ddoi_pkg::CFG_W'($urandom));
         end
         send_random();
      end
      @(negedge clock);
      req_bus.valid = 1'b0;

      // Drain, then allow the unit's latency for any stray beat.
      while (pose_sb.pending_poses.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (pose_sb.mismatches == 0 && pose_sb.pending_poses.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(12 * 3000000);
      $display("status: fail");
      $finish;
   end

endmodule
